[sv/ugq_pkg.sv]
// shared types, register indexes and helpers of the uniform grid quantizer
package ugq_pkg;

	// default configuration of the top level
	localparam int DIMS_DEF       = 4;
	localparam int MAX_POINTS_DEF = 256;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DIMS_W     = 3;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMS_USED = 3'd0,
		CFG_GRID_DIM0 = 3'd1,
		CFG_GRID_DIM1 = 3'd2,
		CFG_GRID_DIM2 = 3'd3,
		CFG_GRID_DIM3 = 3'd4
	} cfg_reg_t;

	// grid word fields
	localparam int ORIGIN_LSB  = 0;
	localparam int SPACING_LSB = 32;
	localparam int SPACING_W   = 24;
	localparam int CMAX_LSB    = 56;
	localparam int CMAX_W      = 8;

	typedef struct packed {
		logic signed [31:0] coord_a;
		logic signed [31:0] coord_b;
		logic signed [31:0] coord_c;
		logic signed [31:0] coord_d;
	} item_t;

	typedef struct packed {
		logic signed [31:0] snapped_a;
		logic signed [31:0] snapped_b;
		logic signed [31:0] snapped_c;
		logic signed [31:0] snapped_d;
		logic        [31:0] cell_index;
	} result_t;

	// last grid point index, limited to the point budget
	function automatic logic [CMAX_W-1:0] cmax_clamp(input logic [CMAX_W-1:0] field,
		input logic [CMAX_W-1:0] lim);
		return (field > lim) ? lim : field;
	endfunction

endpackage

[sv/ugq_stream_if.sv]
// valid/ready stream channel carrying one payload per transfer
interface ugq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[sv/ugq_lane.sv]
// one dimension: restoring divide pipeline, rounding, grid point and index term
module ugq_lane #(
	parameter int MAX_POINTS = ugq_pkg::MAX_POINTS_DEF,
	localparam int KW = $clog2(MAX_POINTS),
	localparam int NL = KW + 4
) (
	input  logic               clk,
	input  logic [NL-1:0]      en,
	input  logic               used,
	input  logic signed [31:0] coord,
	input  logic [63:0]        grid,
	input  logic [31:0]        radix,
	output logic signed [31:0] snap,
	output logic [31:0]        term
);

	localparam logic [ugq_pkg::CMAX_W-1:0] CMAX_LIM = ugq_pkg::CMAX_W'(MAX_POINTS - 1);

	logic signed [31:0]               origin;
	logic [ugq_pkg::SPACING_W-1:0]    spacing;
	logic [ugq_pkg::CMAX_W-1:0]       cmax8;
	logic [KW-1:0]                    cmax_k;

	assign origin  = grid[ugq_pkg::ORIGIN_LSB +: 32];
	assign spacing = grid[ugq_pkg::SPACING_LSB +: ugq_pkg::SPACING_W];
	assign cmax8   = ugq_pkg::cmax_clamp(grid[ugq_pkg::CMAX_LSB +: ugq_pkg::CMAX_W], CMAX_LIM);
	assign cmax_k  = cmax8[KW-1:0];

	// stage 1: offset from the grid origin
	logic signed [32:0] diff_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			diff_s1 <= {coord[31], coord} - {origin[31], origin};
		end
	end

	// stage 2: one quotient bit per cycle unless stalled, most significant first
	logic [31:0]   rem_in  [KW];
	logic [KW-1:0] q_in    [KW];
	logic          ovf_in  [KW];
	logic          pos_in  [KW];
	logic [31:0]   rem_s2  [KW];
	logic [KW-1:0] q_s2    [KW];
	logic          ovf_s2  [KW];
	logic          pos_s2  [KW];

	// quotient too large for the grid, and offset strictly above the origin with a nonzero spacing
	assign rem_in[0] = diff_s1[31:0];
	assign q_in[0]   = '0;
	assign ovf_in[0] = {1'b0, diff_s1[31:0]} >= (33'(spacing) << KW);
	assign pos_in[0] = !diff_s1[32] && (diff_s1 != '0) && (spacing != '0);

	for (genvar i = 0; i < KW; i++) begin : g_div
		localparam int B = KW - 1 - i;
		logic [32:0] sh;
		logic        ge;

		if (i > 0) begin : g_link
			assign rem_in[i] = rem_s2[i-1];
			assign q_in[i]   = q_s2[i-1];
			assign ovf_in[i] = ovf_s2[i-1];
			assign pos_in[i] = pos_s2[i-1];
		end

		assign sh = 33'(spacing) << B;
		assign ge = {1'b0, rem_in[i]} >= sh;

		always_ff @(posedge clk) begin
			if (en[1+i]) begin
				rem_s2[i] <= ge ? 32'({1'b0, rem_in[i]} - sh) : rem_in[i];
				q_s2[i]   <= ge ? (q_in[i] | (KW'(1) << B)) : q_in[i];
				ovf_s2[i] <= ovf_in[i];
				pos_s2[i] <= pos_in[i];
			end
		end
	end

	// stage 3: round half down, clamp to the last grid point, zero if unused or not above the origin
	logic [KW:0]   k_round;
	logic          round_up;
	logic [KW-1:0] k_next;
	logic [KW-1:0] k_s3;

	assign round_up = {rem_s2[KW-1], 1'b0} > 33'(spacing);
	assign k_round  = (KW+1)'(q_s2[KW-1]) + (KW+1)'(round_up);

	always_comb begin
		priority if (!used || !pos_s2[KW-1]) begin
			k_next = '0;
		end else if (ovf_s2[KW-1] || (k_round > (KW+1)'(cmax_k))) begin
			k_next = cmax_k;
		end else begin
			k_next = k_round[KW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[KW+1]) begin
			k_s3 <= k_next;
		end
	end

	// stage 4: grid offset and index term products
	logic [ugq_pkg::SPACING_W+KW-1:0] prod_s4;
	logic [31:0]                      term_s4;

	always_ff @(posedge clk) begin
		if (en[KW+2]) begin
			prod_s4 <= (ugq_pkg::SPACING_W+KW)'(spacing) * (ugq_pkg::SPACING_W+KW)'(k_s3);
			term_s4 <= radix * 32'(k_s3);
		end
	end

	// stage 5: add the origin and saturate to 32 bits, zero for an unused lane
	logic signed [33:0] point;
	logic signed [31:0] point_sat;
	logic signed [31:0] snap_s5;
	logic [31:0]        term_s5;

	assign point = {{2{origin[31]}}, origin} + 34'(prod_s4);

	always_comb begin
		priority if (point[33] && (point[32:31] != 2'b11)) begin
			point_sat = 32'sh8000_0000;
		end else if (!point[33] && (point[32:31] != 2'b00)) begin
			point_sat = 32'sh7fff_ffff;
		end else begin
			point_sat = point[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[KW+3]) begin
			snap_s5 <= used ? point_sat : '0;
			term_s5 <= term_s4;
		end
	end

	assign snap = snap_s5;
	assign term = term_s5;

endmodule

[sv/ugq_merge.sv]
// merge stage: sums the lane index terms and registers the result
module ugq_merge (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] snap [4],
	input  logic [31:0]        term [4],
	output ugq_pkg::result_t   res
);

	ugq_pkg::result_t res_s6;

	// index wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.snapped_a  <= snap[0];
			res_s6.snapped_b  <= snap[1];
			res_s6.snapped_c  <= snap[2];
			res_s6.snapped_d  <= snap[3];
			res_s6.cell_index <= (term[0] + term[1]) + (term[2] + term[3]);
		end
	end

	assign res = res_s6;

endmodule

[sv/uniform_grid_quantizer_unit.sv]
// top level of the uniform grid quantizer: config registers, pipeline control, lanes
//
// channel   dir   payload                                   transfer when
// item      in    coord_a..coord_d, Q16.16                  item.valid & item.ready
// result    out   snapped_a..snapped_d, cell_index          result.valid & result.ready
// cfg       in    cfg_index, cfg_wdata                      cfg_we
//
// One vector per cycle while the result channel takes them; each lane pipelines the origin offset,
// the one-bit-per-cycle divider, rounding, the products and saturation ahead of the merge register.
// Reset gives dims_used = 1 and all grid words zero (one point at the origin).
// Each stage holds while the next one is full and stalled; bubbles are squeezed out,
// so input is taken as long as any stage ahead has room.
module uniform_grid_quantizer_unit #(
	parameter int DIMS       = ugq_pkg::DIMS_DEF,
	parameter int MAX_POINTS = ugq_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ugq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ugq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ugq_stream_if.sink                     item,
	ugq_stream_if.source                   result
);

	localparam int KW  = $clog2(MAX_POINTS);
	localparam int NL  = KW + 4;
	localparam int NST = KW + 5;
	localparam logic [ugq_pkg::CMAX_W-1:0] CMAX_LIM = ugq_pkg::CMAX_W'(MAX_POINTS - 1);

	// configuration registers
	logic [ugq_pkg::DIMS_W-1:0]     dims_q;
	logic [ugq_pkg::CFG_DATA_W-1:0] grid_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= ugq_pkg::DIMS_W'(1);
			for (int d = 0; d < 4; d++) begin
				grid_q[d] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				ugq_pkg::CFG_DIMS_USED: dims_q    <= cfg_wdata[ugq_pkg::DIMS_W-1:0];
				ugq_pkg::CFG_GRID_DIM0: grid_q[0] <= cfg_wdata;
				ugq_pkg::CFG_GRID_DIM1: grid_q[1] <= cfg_wdata;
				ugq_pkg::CFG_GRID_DIM2: grid_q[2] <= cfg_wdata;
				ugq_pkg::CFG_GRID_DIM3: grid_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective dimension count and per-lane use
	logic [ugq_pkg::DIMS_W-1:0] nd;
	logic [3:0]                 used;

	always_comb begin
		priority if (dims_q == '0) begin
			nd = ugq_pkg::DIMS_W'(1);
		end else if (dims_q > ugq_pkg::DIMS_W'(DIMS)) begin
			nd = ugq_pkg::DIMS_W'(DIMS);
		end else begin
			nd = dims_q;
		end
	end

	for (genvar d = 0; d < 4; d++) begin : g_used
		assign used[d] = ugq_pkg::DIMS_W'(d) < nd;
	end

	// grid point counts and mixed-radix weights; settle well before any item
	// reaches the product stage, config being static while items are in flight
	logic [ugq_pkg::CMAX_W:0] cnt   [4];
	logic [31:0]              radix [4];
	logic [31:0]              radix_q [1:3];

	for (genvar d = 0; d < 4; d++) begin : g_cnt
		assign cnt[d] = (ugq_pkg::CMAX_W+1)'(ugq_pkg::cmax_clamp(
			grid_q[d][ugq_pkg::CMAX_LSB +: ugq_pkg::CMAX_W], CMAX_LIM)) +
			(ugq_pkg::CMAX_W+1)'(1);
	end

	assign radix[0] = 32'd1;
	for (genvar d = 1; d < 4; d++) begin : g_radix
		always_ff @(posedge clk) begin
			radix_q[d] <= radix[d-1] * 32'(cnt[d-1]);
		end
		assign radix[d] = radix_q[d];
	end

	// stage valids and enables
	logic [NST:1] vld_q;
	logic [NST:1] en;
	logic [NST:1] vld_in;

	always_comb begin
		en[NST] = !vld_q[NST] || result.ready;
		for (int i = NST - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_in = {vld_q[NST-1:1], item.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign item.ready = en[1];

	// lanes
	logic signed [31:0] coord [4];
	logic signed [31:0] snap  [4];
	logic [31:0]        term  [4];

	assign coord[0] = item.payload.coord_a;
	assign coord[1] = item.payload.coord_b;
	assign coord[2] = item.payload.coord_c;
	assign coord[3] = item.payload.coord_d;

	for (genvar d = 0; d < 4; d++) begin : g_lane
		if (d < DIMS) begin : g_on
			ugq_lane #(
				.MAX_POINTS(MAX_POINTS)
			) u_lane (
				.clk   (clk),
				.en    (en[NL:1]),
				.used  (used[d]),
				.coord (coord[d]),
				.grid  (grid_q[d]),
				.radix (radix[d]),
				.snap  (snap[d]),
				.term  (term[d])
			);
		end else begin : g_off
			assign snap[d] = '0;
			assign term[d] = '0;
		end
	end

	// merge into the output register
	ugq_merge u_merge (
		.clk  (clk),
		.en   (en[NST]),
		.snap (snap),
		.term (term),
		.res  (result.payload)
	);

	assign result.valid = vld_q[NST];

	// checks
	logic [ugq_pkg::CMAX_W-1:0] cmax0;
	assign cmax0 = ugq_pkg::cmax_clamp(grid_q[0][ugq_pkg::CMAX_LSB +: ugq_pkg::CMAX_W], CMAX_LIM);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> item.ready)
		else $error("input stalled with an empty output register");

	a_unused_dim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !used[3] |-> result.payload.snapped_d == '0)
		else $error("unused dimension gave a nonzero value");

	a_single_dim_index: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !used[1] |-> result.payload.cell_index <= 32'(cmax0))
		else $error("one-dimension index beyond the last grid point");

	a_enable_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready && ($countones(vld_q) == NST) |-> !item.ready)
		else $error("input taken while every stage is full and stalled");

endmodule
